/* hdl/fss_pkg.sv */
`default_nettype none

package fss_pkg;

   // Widths fixed by the item and register layout
   localparam int CHAR_W     = 8;
   localparam int QLEN_W     = 6;
   localparam int RUN_W      = 5;
   localparam int SCORE_W    = 11;
   localparam int TRAIL_W    = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int CHARS_PER_WORD = CSR_DATA_W / CHAR_W;

   // Scoring constants
   localparam logic [CHAR_W-1:0] SLASH_CHAR = 8'h2F;
   localparam int RUN_BONUS     = 6;
   localparam int PENALTY_SHIFT = 5;   // trailing count / 32

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_QUERY_LENGTH  = 3'd0,
      CSR_QUERY_CHARS_0 = 3'd1,
      CSR_QUERY_CHARS_1 = 3'd2,
      CSR_QUERY_CHARS_2 = 3'd3,
      CSR_QUERY_CHARS_3 = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [QLEN_W-1:0]  query_pos;
      logic [RUN_W-1:0]   streak_len;
      logic [SCORE_W-1:0] running_score;
      logic               all_matched;
      logic [TRAIL_W-1:0] trailing_count;
   } scoring_state_type;

   typedef struct packed {
      logic               matched;
      logic [SCORE_W-1:0] score;
   } result_type;

   // Lower-case ASCII A-Z, pass every other byte unchanged
   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* hdl/fuzzy_subsequence_scorer_top.sv */
`default_nettype none

// Fuzzy subsequence scorer. Feed a path one byte per item on req_ (tlast on
// its final byte); one result item comes out on rsp_ for each path. Only the
// leaf after the last '/' is scored: each query character matched in order
// (ASCII letters compared without case) adds 1, plus 6 plus the run length
// when it extends a run of consecutive matches. Bytes after the final match
// are counted (saturating at 255) and count/32 is subtracted from the score.
// matched is 0 and score 0 when the query did not fully match; an empty
// query always gives matched = 1, score = 0. Load the query through the csr_
// port (index 0: length, 1..4: eight characters each, lowest byte first)
// while no path is in flight. Throughput is one byte per clock: the per-byte
// compare and score add sit between the scoring state registers and the
// result register, and a path's result appears the cycle after its last
// byte is taken when the output register is free. A spare result register
// sits behind the output register, so req_tready comes straight from a
// register and drops only while two results wait untaken.
module fuzzy_subsequence_scorer_top
   import fss_pkg::*;
#(
   parameter int MAX_QUERY = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // path_char [7:0]
   input  wire logic [7:0]            req_tdata,
   input  wire logic                  req_tlast,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // matched [0], score [11:1], zero [15:12]
   output logic [15:0]                rsp_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int QIDX_W = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;

   logic [QLEN_W-1:0]  query_length_ff;
   logic [CHAR_W-1:0]  query_chars_ff [MAX_QUERY];
   scoring_state_type  state_ff;
   scoring_state_type  state_in;
   logic               rsp_valid_ff;
   result_type         rsp_result_ff;
   logic               spare_valid_ff;
   result_type         spare_result_ff;

   logic [QLEN_W-1:0]  eff_len;
   logic [QIDX_W-1:0]  qidx;
   logic [CHAR_W-1:0]  query_char;
   scoring_state_type  step_state;
   result_type         step_result;
   logic               accept;
   logic               result_load;
   logic               head_free;

   // Configuration: length and query characters
   always_ff @(posedge clock) begin
      if (reset) begin
         query_length_ff <= '0;
      end else if (csr_we && csr_addr == CSR_QUERY_LENGTH) begin
         query_length_ff <= csr_wdata[QLEN_W-1:0];
      end
   end

   for (genvar g = 0; g < MAX_QUERY; g++) begin : g_qchar
      localparam logic [CSR_ADDR_W-1:0] WORD_IDX =
         CSR_ADDR_W'(int'(CSR_QUERY_CHARS_0) + g / CHARS_PER_WORD);
      localparam int BYTE_LSB = (g % CHARS_PER_WORD) * CHAR_W;
      always_ff @(posedge clock) begin
         if (reset) begin
            query_chars_ff[g] <= '0;
         end else if (csr_we && csr_addr == WORD_IDX) begin
            query_chars_ff[g] <= csr_wdata[BYTE_LSB +: CHAR_W];
         end
      end
   end

   // Clamp length to the query storage
   assign eff_len = (query_length_ff > QLEN_W'(MAX_QUERY)) ? QLEN_W'(MAX_QUERY)
                                                           : query_length_ff;

   // Pick the next query character to match; unused once query_pos reaches eff_len
   assign qidx       = state_ff.query_pos[QIDX_W-1:0];
   assign query_char = query_chars_ff[qidx];

   fss_step u_step (
      .cur_state  (state_ff),
      .path_char  (req_tdata),
      .eff_len    (eff_len),
      .query_char (query_char),
      .next_state (step_state),
      .result     (step_result)
   );

   // Take a byte whenever the spare result slot is empty
   assign req_tready  = !spare_valid_ff;
   assign accept      = req_tvalid && req_tready;
   assign result_load = accept && req_tlast;
   assign head_free   = !rsp_valid_ff || rsp_tready;

   // Advance scoring state; clear it after the last byte of a path
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = req_tlast ? '0 : step_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // Output register refills from the spare first, else from a new last byte;
   // the spare catches a result only while the output register is held.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         if (head_free) begin
            rsp_valid_ff <= spare_valid_ff || result_load;
         end
         spare_valid_ff <= spare_valid_ff ? !head_free : (result_load && !head_free);
      end
   end

   always_ff @(posedge clock) begin
      if (head_free && (spare_valid_ff || result_load)) begin
         rsp_result_ff <= spare_valid_ff ? spare_result_ff : step_result;
      end
      if (result_load && !head_free) begin
         spare_result_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_result_ff.score, rsp_result_ff.matched};

endmodule

`default_nettype wire

/* hdl/fss_step.sv */
`default_nettype none

module fss_step
   import fss_pkg::*;
(
   input  wire scoring_state_type  cur_state,
   input  wire logic [CHAR_W-1:0]  path_char,
   input  wire logic [QLEN_W-1:0]  eff_len,
   input  wire logic [CHAR_W-1:0]  query_char,
   output scoring_state_type       next_state,
   output result_type              result
);

   logic               hit;
   logic [SCORE_W-1:0] add;
   logic [QLEN_W-1:0]  pos_inc;
   logic [SCORE_W-1:0] penalty;

   assign hit     = fold_char(path_char) == fold_char(query_char);
   assign add     = (cur_state.streak_len == '0) ? SCORE_W'(1)
                  : SCORE_W'(1 + RUN_BONUS) + SCORE_W'(cur_state.streak_len);
   assign pos_inc = cur_state.query_pos + QLEN_W'(1);

   always_comb begin
      next_state = cur_state;
      if (path_char == SLASH_CHAR) begin
         next_state = '0;
      end else if (cur_state.all_matched) begin
         if (cur_state.trailing_count != '1) begin
            next_state.trailing_count = cur_state.trailing_count + TRAIL_W'(1);
         end
      end else if (eff_len != '0 && cur_state.query_pos < eff_len) begin
         if (hit) begin
            next_state.running_score = cur_state.running_score + add;
            if (cur_state.streak_len != '1) begin
               next_state.streak_len = cur_state.streak_len + RUN_W'(1);
            end
            next_state.query_pos = pos_inc;
            if (pos_inc >= eff_len) begin
               next_state.all_matched = 1'b1;
            end
         end else begin
            next_state.streak_len = '0;
         end
      end
   end

   assign penalty = SCORE_W'(next_state.trailing_count >> PENALTY_SHIFT);

   always_comb begin
      if (eff_len == '0) begin
         result.matched = 1'b1;
         result.score   = '0;
      end else if (next_state.all_matched) begin
         result.matched = 1'b1;
         result.score   = next_state.running_score - penalty;
      end else begin
         result.matched = 1'b0;
         result.score   = '0;
      end
   end

endmodule

`default_nettype wire

/* sim/tb_fuzzy_subsequence_scorer_top.sv */
`default_nettype none

module tb_fuzzy_subsequence_scorer_top;
   import fss_pkg::*;

   localparam int CLK_HALF       = 4;
   localparam int QUERY_SLOTS    = 32;
   localparam int RANDOM_ITEMS   = 1000;
   localparam int QUIET_TAIL     = 150;      // last bytes of the run go without idling
   localparam int TIMEOUT_CYCLES = 400_000;

   // Shadow of the scorer: holds its own copy of the query registers and the
   // per-leaf scoring state, and queues the result that each path must produce.
   class leaf_score_tracker;
      logic [QLEN_W-1:0]     qlen;
      logic [CSR_DATA_W-1:0] qwords [4];
      logic [QLEN_W-1:0]     pos;
      logic [RUN_W-1:0]      run;
      logic [SCORE_W-1:0]    score;
      bit                    done;
      logic [TRAIL_W-1:0]    trail;
      result_type            due_scores [$];
      int                    errors;
      int                    scored;
      int                    full_hits;
      int                    negatives;

      function new();
         qlen = '0;
         foreach (qwords[k]) qwords[k] = '0;
         errors = 0;
         scored = 0;
         full_hits = 0;
         negatives = 0;
         clear_leaf();
      endfunction

      function void clear_leaf();
         pos   = '0;
         run   = '0;
         score = '0;
         done  = 1'b0;
         trail = '0;
      endfunction

      function logic [CHAR_W-1:0] lower_ascii(logic [CHAR_W-1:0] c);
         return (c >= "A" && c <= "Z") ? c ^ 8'h20 : c;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_QUERY_LENGTH:  qlen = v[QLEN_W-1:0];
            CSR_QUERY_CHARS_0: qwords[0] = v;
            CSR_QUERY_CHARS_1: qwords[1] = v;
            CSR_QUERY_CHARS_2: qwords[2] = v;
            CSR_QUERY_CHARS_3: qwords[3] = v;
            default: ;
         endcase
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10) $display("[%0t] MISMATCH %s", $realtime, what);
      endfunction

      // Advance the leaf state by one accepted path byte.
      function void take_char(logic [CHAR_W-1:0] c, bit last);
         logic [QLEN_W-1:0]  n;
         logic [CHAR_W-1:0]  q;
         logic [SCORE_W-1:0] add;
         result_type         r;
         n = (qlen > QLEN_W'(QUERY_SLOTS)) ? QLEN_W'(QUERY_SLOTS) : qlen;
         if (c == SLASH_CHAR) begin
            clear_leaf();
         end else if (done) begin
            if (trail != '1) trail++;
         end else if (n != 0 && pos < n) begin
            q = qwords[pos[4:3]][{pos[2:0], 3'b000} +: CHAR_W];
            if (lower_ascii(c) == lower_ascii(q)) begin
               add = 11'd1;
               if (run != 0) add = SCORE_W'(1 + RUN_BONUS + run);
               score = score + add;
               if (run != '1) run++;
               pos++;
               if (pos >= n) done = 1'b1;
            end else begin
               run = '0;
            end
         end
         if (!last) return;
         if (n == 0) begin
            r.matched = 1'b1;
            r.score   = '0;
         end else if (done) begin
            r.matched = 1'b1;
            r.score   = score - SCORE_W'(trail >> PENALTY_SHIFT);
         end else begin
            r.matched = 1'b0;
            r.score   = '0;
         end
         due_scores.insert(due_scores.size(), r);
         clear_leaf();
      endfunction

      function void check_score(logic [15:0] d);
         result_type want;
         scored++;
         if (d[0]) full_hits++;
         if (d[0] && d[SCORE_W]) negatives++;
         if (due_scores.size() == 0) begin
            flag($sformatf("unexpected result matched=%0b score=%0d",
                           d[0], $signed(d[SCORE_W:1])));
            return;
         end
         want = due_scores.pop_front();
         if (d[0] !== want.matched || d[SCORE_W:1] !== want.score)
            flag($sformatf("expected matched=%0b score=%0d, got matched=%0b score=%0d",
                           want.matched, $signed(want.score),
                           d[0], $signed(d[SCORE_W:1])));
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [7:0]            req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   leaf_score_tracker book = new();

   // Query bytes staged for the next configuration load
   logic [CHAR_W-1:0] qbuf [QUERY_SLOTS];
   int                eff_len = 0;
   logic [CHAR_W-1:0] leaf_bytes [$];

   int  items_sent = 0;
   int  paths_sent = 0;
   int  settings   = 0;
   int  gap_pct    = 0;
   int  stall_pct  = 0;
   int  stall_left = 0;
   bit  quiet      = 1'b0;
   int  run_target = 0;

   fuzzy_subsequence_scorer_top #(.MAX_QUERY(QUERY_SLOTS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Result side: hold tready low in random bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < stall_pct) begin
         stall_left <= $urandom_range(14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check every result item taken by the receiver.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         book.check_score(rsp_tdata);
   end

   function automatic void add_byte(input logic [CHAR_W-1:0] c);
      leaf_bytes.insert(leaf_bytes.size(), c);
   endfunction

   // Write one register; the caller lowers csr_we after its last write.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      book.set_reg(idx, v);
      @(negedge clock);
   endtask

   // Load query length and all four character words from qbuf. Junk goes into
   // the unused upper length bits, which the block must drop.
   task automatic load_query(input logic [QLEN_W-1:0] len);
      logic [CSR_DATA_W-1:0] w [4];
      logic [CSR_DATA_W-1:0] lw;
      for (int k = 0; k < 4; k++)
         for (int j = 0; j < CHARS_PER_WORD; j++)
            w[k][CHAR_W*j +: CHAR_W] = qbuf[CHARS_PER_WORD*k + j];
      lw = {$urandom, $urandom};
      lw[QLEN_W-1:0] = len;
      write_reg(CSR_QUERY_LENGTH, lw);
      write_reg(CSR_QUERY_CHARS_0, w[0]);
      write_reg(CSR_QUERY_CHARS_1, w[1]);
      write_reg(CSR_QUERY_CHARS_2, w[2]);
      write_reg(CSR_QUERY_CHARS_3, w[3]);
      csr_we  <= 1'b0;
      eff_len  = (len > QUERY_SLOTS) ? QUERY_SLOTS : int'(len);
      settings++;
   endtask

   // Offer one path byte, optionally after an idle burst, and wait for it to go in.
   task automatic send_char(input logic [CHAR_W-1:0] c, input bit last);
      int gap;
      gap = (!quiet && $urandom_range(99) < gap_pct) ? $urandom_range(1, 15) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= c;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      book.take_char(c, last);
      items_sent++;
      if (run_target != 0 && items_sent >= run_target - QUIET_TAIL) quiet = 1'b1;
      @(negedge clock);
   endtask

   task automatic send_path();
      foreach (leaf_bytes[i]) send_char(leaf_bytes[i], i == leaf_bytes.size() - 1);
      paths_sent++;
   endtask

   // Drop valid, drain every pending result, then let the pipeline go quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (book.due_scores.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [CHAR_W-1:0] flip_case(logic [CHAR_W-1:0] c);
      if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && $urandom_range(1))
         return c ^ 8'h20;
      return c;
   endfunction

   // Filler byte for a leaf: never a slash, mostly printable.
   function automatic logic [CHAR_W-1:0] pick_filler();
      logic [CHAR_W-1:0] c;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: c = flip_case(8'("a" + $urandom_range(25)));
         5, 6:          c = 8'("0" + $urandom_range(9));
         7:             c = ".";
         default:       c = 8'($urandom_range(255));
      endcase
      return (c == SLASH_CHAR) ? 8'("_") : c;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_query_char();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return flip_case(8'("a" + $urandom_range(25)));
         6:                return 8'("0" + $urandom_range(9));
         7:                return ($urandom_range(1)) ? 8'(".") : 8'("_");
         default:          return 8'($urandom_range(255));
      endcase
   endfunction

   // Directory prefix, then the query spread over the leaf with random fillers
   // and case, then trailing bytes. A broken path loses one query character
   // and may end on a slash.
   task automatic build_leaf_path(input bit broken);
      int drop;
      int gap_max;
      int tail;
      int r;
      leaf_bytes.delete();
      repeat ($urandom_range(2)) begin
         repeat ($urandom_range(4)) add_byte(pick_filler());
         add_byte(SLASH_CHAR);
      end
      drop    = (broken && eff_len > 0) ? $urandom_range(eff_len - 1) : -1;
      gap_max = ($urandom_range(99) < 40) ? 0 : 3;
      for (int i = 0; i < eff_len; i++) begin
         repeat ($urandom_range(gap_max)) add_byte(pick_filler());
         if (i != drop) add_byte(flip_case(qbuf[i]));
      end
      r    = $urandom_range(99);
      tail = (r < 4) ? $urandom_range(250, 300) :
             (r < 15) ? $urandom_range(32, 120) : $urandom_range(12);
      repeat (tail) add_byte(pick_filler());
      if (broken && $urandom_range(1)) add_byte(SLASH_CHAR);
      if (leaf_bytes.size() == 0) add_byte(pick_filler());
   endtask

   task automatic build_noise_path();
      leaf_bytes.delete();
      repeat ($urandom_range(1, 20)) begin
         if ($urandom_range(9) == 0) add_byte(SLASH_CHAR);
         else add_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic pick_query();
      logic [QLEN_W-1:0] len;
      case ($urandom_range(9))
         0:       len = '0;
         1, 2, 3: len = QLEN_W'($urandom_range(1, 4));
         4, 5:    len = QLEN_W'($urandom_range(5, 10));
         6:       len = QLEN_W'($urandom_range(11, 31));
         7:       len = QLEN_W'(QUERY_SLOTS);
         8:       len = QLEN_W'($urandom_range(33, 63));
         default: len = QLEN_W'($urandom_range(1, 3));
      endcase
      foreach (qbuf[i]) qbuf[i] = pick_query_char();
      load_query(len);
   endtask

   initial begin
      int pick;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset config is an empty query: any path, even one ending on a slash,
      // scores as a match worth zero.
      gap_pct   = 0;
      stall_pct = 0;
      leaf_bytes = '{8'h71};
      send_path();
      leaf_bytes = '{8'h61, SLASH_CHAR};
      send_path();
      settle();

      // Query mixing case, a zero byte and a high byte that must not fold.
      foreach (qbuf[i]) qbuf[i] = 8'h00;
      qbuf[0] = "a";
      qbuf[1] = "B";
      qbuf[2] = 8'h00;
      qbuf[3] = 8'hC1;
      load_query(6'd4);
      gap_pct   = 30;
      stall_pct = 30;
      leaf_bytes = '{"A", "b", 8'h00, 8'hC1};                // one tight run
      send_path();
      leaf_bytes = '{"x", "A", "b", 8'h00, 8'hE1};           // high byte not folded
      send_path();
      leaf_bytes = '{"a", SLASH_CHAR};                       // empty leaf at the end
      send_path();
      leaf_bytes = '{8'hFF};
      send_path();
      leaf_bytes = '{"a", ".", "b", 8'h00, 8'hC1, "z"};      // broken run, one trailer
      send_path();

      // Random phases: new query and idle mix each time, mostly leaves that
      // contain the query, some broken ones and some raw noise.
      run_target = items_sent + RANDOM_ITEMS;
      while (items_sent < run_target) begin
         settle();
         pick_query();
         case ($urandom_range(3))
            0:       gap_pct = 0;
            1:       gap_pct = 5;
            2:       gap_pct = 20;
            default: gap_pct = 50;
         endcase
         case ($urandom_range(3))
            0:       stall_pct = 0;
            1:       stall_pct = 5;
            2:       stall_pct = 20;
            default: stall_pct = 50;
         endcase
         repeat ($urandom_range(3, 10)) begin
            pick = $urandom_range(99);
            if (pick < 70) build_leaf_path(1'b0);
            else if (pick < 85) build_leaf_path(1'b1);
            else build_noise_path();
            send_path();
         end
      end

      settle();
      repeat (8) @(negedge clock);
      if (book.due_scores.size() != 0)
         book.flag($sformatf("%0d results never arrived", book.due_scores.size()));
      $display("Scored %0d paths (%0d bytes, %0d results) under %0d query settings:",
               paths_sent, items_sent, book.scored, settings);
      $display("%0d full matches, %0d with negative score after trailing penalty, %0d mismatches",
               book.full_hits, book.negatives, book.errors);
      if (book.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Hard stop in case a handshake hangs.
   initial begin
      #(2 * CLK_HALF * TIMEOUT_CYCLES);
      $display("Timed out after %0d cycles", TIMEOUT_CYCLES);
      $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

/* fuzzy_subsequence_scorer_top.f */
hdl/fss_pkg.sv
hdl/fss_step.sv
hdl/fuzzy_subsequence_scorer_top.sv
sim/tb_fuzzy_subsequence_scorer_top.sv
